>>> rtl/core/sfla_pkg.sv
// ----------------------------------------------------------------------------
// sfla_pkg: shared types and constants
// Header layout, request/response items and fit policy codes for the
// sorted free list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int unsigned ARENA_BYTES  = 4096;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned ADDR_W       = $clog2(ARENA_BYTES);
  localparam int unsigned SIZE_W       = 13;
  localparam int unsigned REQ_W        = 13;

  // Block header: next link, link valid, payload size
  typedef struct packed {
    logic [ADDR_W-1:0] next;
    logic              has_next;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  typedef struct packed {
    logic              operation;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] free_offset;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] payload_offset;
  } rsp_t;

  // Header memory access from the controller
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    hdr_t              wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_RSVD  = 2'd3
  } fit_pol_e;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_NOFIT = 1'b1;

endpackage

>>> rtl/core/sfla_mem.sv
// ----------------------------------------------------------------------------
// sfla_mem: header store
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sfla_mem (
  input  logic               clk_i,
  input  sfla_pkg::mem_req_t mem_req_i,
  output sfla_pkg::hdr_t     rdata_o
);
  import sfla_pkg::*;

  hdr_t mem_q [ARENA_BYTES];

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    rdata_o <= mem_q[mem_req_i.raddr];
  end

endmodule

>>> rtl/core/sfla_ctrl.sv
// ----------------------------------------------------------------------------
// sfla_ctrl: allocator sequencer
// Clears the header store after reset, walks the free list one header per
// read, then commits up to three header writes and the list head.
// ----------------------------------------------------------------------------
module sfla_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  sfla_pkg::req_t     req_i,
  input  logic [1:0]         fit_policy_i,
  output logic               result_valid_o,
  output sfla_pkg::rsp_t     rsp_o,
  output sfla_pkg::mem_req_t mem_req_o,
  input  sfla_pkg::hdr_t     mem_rdata_i
);
  import sfla_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_A_RD  = 11'b00000000100,
    S_A_EV  = 11'b00000001000,
    S_A_FIN = 11'b00000010000,
    S_F_RD  = 11'b00000100000,
    S_F_EV  = 11'b00001000000,
    S_F_RDB = 11'b00010000000,
    S_F_EVB = 11'b00100000000,
    S_WR    = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_e;

  localparam logic [ADDR_W-1:0] HDR_A    = ADDR_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] HDR_S    = SIZE_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] INIT_SZ  = SIZE_W'(ARENA_BYTES - HEADER_BYTES);
  // a list walk follows at most one link per arena byte
  localparam logic [ADDR_W:0]   WALK_MAX = (ADDR_W+1)'(ARENA_BYTES);

  state_e state_q, state_d;

  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [ADDR_W-1:0] head_q, head_d;
  logic              head_v_q, head_v_d;

  // walk state
  logic [ADDR_W-1:0] cur_q, cur_d, prev_q, prev_d;
  logic              has_cur_q, has_cur_d, has_prev_q, has_prev_d;
  logic [SIZE_W-1:0] prev_size_q, prev_size_d;
  logic [ADDR_W:0]   steps_q, steps_d;
  // captured item
  logic              op_q, op_d;
  logic [REQ_W-1:0]  rbytes_q, rbytes_d;
  logic [ADDR_W-1:0] blk_q, blk_d;
  // selected block (alloc) / stop header (free)
  logic              found_q, found_d;
  logic [ADDR_W-1:0] sel_q, sel_d, sel_prev_q, sel_prev_d, sel_next_q, sel_next_d;
  logic              sel_hn_q, sel_hn_d, sel_has_prev_q, sel_has_prev_d;
  logic [SIZE_W-1:0] sel_size_q, sel_size_d, sel_prev_size_q, sel_prev_size_d;

  // pending header writes
  logic [2:0]        wen_q, wen_d;
  logic [ADDR_W-1:0] wad_q [3];
  logic [ADDR_W-1:0] wad_d [3];
  hdr_t              wdt_q [3];
  hdr_t              wdt_d [3];
  logic [1:0]        wi_q, wi_d;

  rsp_t rsp_q, rsp_d;

  // alloc decode
  logic              fits, better, take_first, split;
  logic [13:0]       rem_w;
  logic [13:0]       need_w;
  logic [SIZE_W-1:0] rem_size, relink_size;
  // free decode
  logic [13:0]       bend_w, pend_w;
  logic              adjc, adjp;
  logic [SIZE_W-1:0] bsize_n;
  logic [ADDR_W-1:0] bnext_n;
  logic              bhn_n;

  assign take_first = (fit_policy_i != POL_BEST) && (fit_policy_i != POL_WORST);
  assign fits       = mem_rdata_i.size >= rbytes_q;
  assign better     = !found_q || take_first
                    || (fit_policy_i == POL_BEST  && mem_rdata_i.size < sel_size_q)
                    || (fit_policy_i == POL_WORST && mem_rdata_i.size > sel_size_q);
  assign rem_w      = 14'(sel_q) + 14'(HEADER_BYTES) + 14'(rbytes_q);
  assign need_w     = 14'(rbytes_q) + 14'(HEADER_BYTES + 1);
  assign split      = (14'(sel_size_q) >= need_w) && (rem_w[13:ADDR_W] == '0);
  assign rem_size   = SIZE_W'(sel_size_q - SIZE_W'(rbytes_q) - HDR_S);
  // predecessor keeps its size unless it is a header rewritten by the split
  assign relink_size = (split && sel_prev_q == sel_q) ? SIZE_W'(rbytes_q)
                     : (split && sel_prev_q == rem_w[ADDR_W-1:0]) ? rem_size
                     : sel_prev_size_q;

  // free merge terms, block header in mem_rdata_i during S_F_EVB
  assign bend_w  = 14'(blk_q) + 14'(HEADER_BYTES) + 14'(mem_rdata_i.size);
  assign adjc    = has_cur_q && (bend_w == 14'(sel_q));
  assign bsize_n = adjc ? SIZE_W'(mem_rdata_i.size + HDR_S + sel_size_q)
                        : mem_rdata_i.size;
  assign bnext_n = adjc ? sel_next_q : sel_q;
  assign bhn_n   = adjc ? sel_hn_q : has_cur_q;
  assign pend_w  = 14'(prev_q) + 14'(HEADER_BYTES) + 14'(prev_size_q);
  assign adjp    = has_prev_q && (pend_w == 14'(blk_q));

  always_comb begin
    state_d         = state_q;
    clr_d           = clr_q;
    head_d          = head_q;
    head_v_d        = head_v_q;
    cur_d           = cur_q;
    prev_d          = prev_q;
    has_cur_d       = has_cur_q;
    has_prev_d      = has_prev_q;
    prev_size_d     = prev_size_q;
    steps_d         = steps_q;
    op_d            = op_q;
    rbytes_d        = rbytes_q;
    blk_d           = blk_q;
    found_d         = found_q;
    sel_d           = sel_q;
    sel_prev_d      = sel_prev_q;
    sel_next_d      = sel_next_q;
    sel_hn_d        = sel_hn_q;
    sel_has_prev_d  = sel_has_prev_q;
    sel_size_d      = sel_size_q;
    sel_prev_size_d = sel_prev_size_q;
    wen_d           = wen_q;
    wad_d           = wad_q;
    wdt_d           = wdt_q;
    wi_d            = wi_q;
    rsp_d           = rsp_q;
    mem_req_o       = '0;

    case (state_q)
      // initialize header store, one entry per cycle
      S_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = clr_q;
        if (clr_q == '0) begin
          mem_req_o.wdata.size = INIT_SZ;
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_d       = req_i.operation;
          rbytes_d   = req_i.request_bytes;
          blk_d      = req_i.free_offset - HDR_A;
          cur_d      = head_q;
          has_cur_d  = head_v_q;
          has_prev_d = 1'b0;
          steps_d    = '0;
          found_d    = 1'b0;
          wen_d      = '0;
          wi_d       = '0;
          rsp_d      = '0;
          if (req_i.operation == OP_ALLOC) begin
            state_d = S_A_RD;
          end else if (req_i.free_offset < HDR_A) begin
            state_d = S_DONE;
          end else begin
            state_d = S_F_RD;
          end
        end
      end
      // allocate: walk whole list (first fit stops early)
      S_A_RD: begin
        mem_req_o.raddr = cur_q;
        state_d = (has_cur_q && steps_q != WALK_MAX) ? S_A_EV : S_A_FIN;
      end
      S_A_EV: begin
        state_d = S_A_RD;
        steps_d = steps_q + 1'b1;
        if (fits && better) begin
          found_d         = 1'b1;
          sel_d           = cur_q;
          sel_size_d      = mem_rdata_i.size;
          sel_next_d      = mem_rdata_i.next;
          sel_hn_d        = mem_rdata_i.has_next;
          sel_prev_d      = prev_q;
          sel_has_prev_d  = has_prev_q;
          sel_prev_size_d = prev_size_q;
          if (take_first) begin
            state_d = S_A_FIN;
          end
        end
        prev_d      = cur_q;
        prev_size_d = mem_rdata_i.size;
        has_prev_d  = 1'b1;
        cur_d       = mem_rdata_i.next;
        has_cur_d   = mem_rdata_i.has_next;
      end
      S_A_FIN: begin
        if (!found_q) begin
          rsp_d.status = ST_NOFIT;
          state_d      = S_DONE;
        end else begin
          rsp_d.status         = ST_OK;
          rsp_d.payload_offset = sel_q + HDR_A;
          // remainder header, then trimmed block
          wen_d[0]          = split;
          wad_d[0]          = rem_w[ADDR_W-1:0];
          wdt_d[0].next     = sel_next_q;
          wdt_d[0].has_next = sel_hn_q;
          wdt_d[0].size     = rem_size;
          wen_d[1]          = split;
          wad_d[1]          = sel_q;
          wdt_d[1].next     = '0;
          wdt_d[1].has_next = 1'b0;
          wdt_d[1].size     = SIZE_W'(rbytes_q);
          // relink predecessor or head
          wen_d[2]          = sel_has_prev_q;
          wad_d[2]          = sel_prev_q;
          wdt_d[2].next     = split ? rem_w[ADDR_W-1:0] : sel_next_q;
          wdt_d[2].has_next = split ? 1'b1 : sel_hn_q;
          wdt_d[2].size     = relink_size;
          if (!sel_has_prev_q) begin
            head_d   = wdt_d[2].next;
            head_v_d = wdt_d[2].has_next;
          end
          state_d = S_WR;
        end
      end
      // free: walk to first block at or above the freed one
      S_F_RD: begin
        mem_req_o.raddr = cur_q;
        state_d = has_cur_q ? S_F_EV : S_F_RDB;
      end
      S_F_EV: begin
        if (cur_q < blk_q && steps_q != WALK_MAX) begin
          prev_d      = cur_q;
          prev_size_d = mem_rdata_i.size;
          has_prev_d  = 1'b1;
          cur_d       = mem_rdata_i.next;
          has_cur_d   = mem_rdata_i.has_next;
          steps_d     = steps_q + 1'b1;
          state_d     = S_F_RD;
        end else begin
          sel_d      = cur_q;
          sel_size_d = mem_rdata_i.size;
          sel_next_d = mem_rdata_i.next;
          sel_hn_d   = mem_rdata_i.has_next;
          state_d    = (cur_q == blk_q) ? S_DONE : S_F_RDB;
        end
      end
      S_F_RDB: begin
        mem_req_o.raddr = blk_q;
        if (!has_cur_q) begin
          sel_d = cur_q;
        end
        state_d = S_F_EVB;
      end
      S_F_EVB: begin
        wen_d[0]          = 1'b1;
        wad_d[0]          = blk_q;
        wdt_d[0].next     = bnext_n;
        wdt_d[0].has_next = bhn_n;
        wdt_d[0].size     = bsize_n;
        wen_d[1]          = has_prev_q;
        wad_d[1]          = prev_q;
        wdt_d[1].next     = adjp ? bnext_n : blk_q;
        wdt_d[1].has_next = adjp ? bhn_n : 1'b1;
        wdt_d[1].size     = adjp ? SIZE_W'(prev_size_q + HDR_S + bsize_n) : prev_size_q;
        if (!has_prev_q) begin
          head_d   = blk_q;
          head_v_d = 1'b1;
        end
        state_d = S_WR;
      end
      // commit pending writes in order
      S_WR: begin
        mem_req_o.we    = wen_q[wi_q];
        mem_req_o.waddr = wad_q[wi_q];
        mem_req_o.wdata = wdt_q[wi_q];
        wi_d = wi_q + 1'b1;
        if (wi_q == 2'd2) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      head_q   <= '0;
      head_v_q <= 1'b1;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      head_q   <= head_d;
      head_v_q <= head_v_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cur_q           <= cur_d;
    prev_q          <= prev_d;
    has_cur_q       <= has_cur_d;
    has_prev_q      <= has_prev_d;
    prev_size_q     <= prev_size_d;
    steps_q         <= steps_d;
    op_q            <= op_d;
    rbytes_q        <= rbytes_d;
    blk_q           <= blk_d;
    found_q         <= found_d;
    sel_q           <= sel_d;
    sel_prev_q      <= sel_prev_d;
    sel_next_q      <= sel_next_d;
    sel_hn_q        <= sel_hn_d;
    sel_has_prev_q  <= sel_has_prev_d;
    sel_size_q      <= sel_size_d;
    sel_prev_size_q <= sel_prev_size_d;
    wen_q           <= wen_d;
    wad_q           <= wad_d;
    wdt_q           <= wdt_d;
    wi_q            <= wi_d;
    rsp_q           <= (op_d == OP_FREE) ? rsp_t'('0) : rsp_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_DONE);
  assign rsp_o          = rsp_q;

endmodule

>>> rtl/core/sorted_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// sorted_free_list_allocator_top: first/best/worst fit heap allocator
// Address-sorted free list over a 4096 byte arena with header memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 4096-entry header store, one entry per
// cycle, holding busy high. An item is taken when start is high and busy
// low; busy stays high until its result, which is on rsp_o for the one
// cycle result_valid_o is high and cannot be stalled. The walk issues each
// header read in one state and evaluates the registered data in the next
// (separate write port). An allocate walks every free block, then writes
// the split and relink headers; it skips the writes when nothing fits and
// under first fit stops at the first block that fits. A free walks the
// free blocks below it, reads its own header and writes the merged headers;
// it ends after the walk if the block is already free and skips the walk
// for a null or too low offset. Walks stop after 4096 links. The next item
// can be taken the cycle after the result strobe. fit_policy is to be written
// through the cfg channel only while idle; the block itself does not enforce it.
module sorted_free_list_allocator_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  sfla_pkg::req_t   req_i,
  output logic             result_valid_o,
  output sfla_pkg::rsp_t   rsp_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_data_i
);
  import sfla_pkg::*;

  logic [1:0] fit_policy_q;
  mem_req_t   mem_req;
  hdr_t       mem_rdata;

  // policy register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_policy_q <= POL_FIRST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fit_policy_q <= cfg_data_i;
    end
  end

  sfla_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .fit_policy_i   (fit_policy_q),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata)
  );

  sfla_mem u_mem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (mem_rdata)
  );

  // a result is shown only while an item is in flight
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result outside busy");

  // accepted item raises busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accept without busy");

  // one result per item
  a_res_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result repeated");

  // failure carries no offset
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && rsp_o.status == ST_NOFIT) |-> (rsp_o.payload_offset == '0))
    else $error("offset on failure");

endmodule
